// ===== src/evad_pkg.sv =====
// Package for the energy voice activity detector: constants, register map, state type.
package evad_pkg;

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_HP_ALPHA   = 3'd0,
    REG_HP_ENABLE  = 3'd1,
    REG_TOTAL      = 3'd2,
    REG_WINDOW     = 3'd3,
    REG_THRESHOLD  = 3'd4
  } cfg_reg_e;

  // Fixed-point formats
  localparam int ALPHA_BITS = 16;  // Q1.15
  localparam int ALPHA_FRAC = 15;
  localparam int THR_BITS   = 16;  // Q4.12
  localparam int THR_FRAC   = 12;

  // Digit width of the serial multiplier
  localparam int DIGIT_BITS = 4;

  // Register reset values
  localparam int ALPHA_RST  = 31533;
  localparam int ENABLE_RST = 1;
  localparam int TOTAL_RST  = 32000;
  localparam int WINDOW_RST = 16000;
  localparam int THR_RST    = 2458;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a sample
    ST_FILT,   // high-pass product running
    ST_ACC,    // filter state and energy sums update
    ST_LHS,    // window sum times buffer length
    ST_R1,     // overall sum times threshold
    ST_RHS,    // previous product times window length, then compare
    ST_SPARE   // unused
  } state_e;

endpackage

// ===== src/evad_if.sv =====
// Channel interfaces of the energy voice activity detector: samples, results, configuration.
interface evad_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface evad_result_if #(
  parameter int SUM_BITS = 37
);
  logic                valid;
  logic                ready;
  logic                quiet_end;
  logic                too_short;
  logic [SUM_BITS-1:0] energy_all_sum;
  logic [SUM_BITS-1:0] energy_last_sum;

  modport source (output valid, output quiet_end, output too_short,
                  output energy_all_sum, output energy_last_sum, input ready);
  modport sink   (input valid, input quiet_end, input too_short,
                  input energy_all_sum, input energy_last_sum, output ready);
endinterface

interface evad_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [evad_pkg::CFG_ADDR_BITS-1:0]  addr;
  logic [evad_pkg::CFG_DATA_BITS-1:0]  wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== src/evad_dsmul.sv =====
// Digit-serial unsigned multiplier: one digit of the second operand per cycle, LSB first.
module evad_dsmul #(
  parameter int A_BITS = 53,
  parameter int B_BITS = 21
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [A_BITS-1:0]        a_i,
  input  logic [B_BITS-1:0]        b_i,
  output logic                     done_o,
  output logic [A_BITS+B_BITS-1:0] prod_o
);

  localparam int P_BITS = A_BITS + B_BITS;
  localparam int D_BITS = evad_pkg::DIGIT_BITS;

  logic [P_BITS-1:0] acc_q, ash_q;
  logic [B_BITS-1:0] brem_q;
  logic [D_BITS-1:0] digit;
  logic [P_BITS-1:0] part;

  assign digit  = brem_q[D_BITS-1:0];
  assign part   = P_BITS'(ash_q * digit);
  // product is final once no nonzero digit is left
  assign done_o = (brem_q == '0);
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brem_q <= '0;
    end else if (start_i) begin
      brem_q <= b_i;
    end else if (!done_o) begin
      brem_q <= brem_q >> D_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      ash_q <= P_BITS'(a_i);
    end else if (!done_o) begin
      acc_q <= acc_q + part;
      ash_q <= ash_q << D_BITS;
    end
  end

endmodule

// ===== src/energy_voice_activity_detector.sv =====
// Energy voice activity detector top level: high-pass filter, energy sums, end-of-buffer test.
// Per sample: with the filter bypassed (or on the first sample of a buffer) the sequencer
//   steps IDLE, ACC; with it on, IDLE, FILT while the 4-bit digit multiplier forms alpha*s, ACC.
// A new sample is accepted only in IDLE, so not while the previous one is still being processed.
// The last sample of a buffer then runs LHS, R1 and RHS on the same multiplier,
//   and the block stays in RHS while the result beat waits.
// Reset (rst_ni low, asynchronous): registers to their defaults, filter and sums cleared.
module energy_voice_activity_detector #(
  parameter int COUNT_BITS  = 20,
  parameter int SAMPLE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  evad_sample_if.sink   in_i,
  evad_result_if.source out_o,
  evad_cfg_if.sink      cfg_i
);

  // ---------------------------------------------------------------------------
  // Widths
  // ---------------------------------------------------------------------------
  localparam int FILT_BITS = SAMPLE_BITS + 2;            // filter output, signed
  localparam int DIFF_BITS = FILT_BITS + 1;              // y + x - x_prev, signed
  localparam int SUM_BITS  = COUNT_BITS + SAMPLE_BITS + 1;
  localparam int TOT_BITS  = COUNT_BITS + 1;             // buffer length, 0 means 2^COUNT_BITS
  localparam int MA_BITS   = SUM_BITS + evad_pkg::THR_BITS;
  localparam int MB_BITS   = (TOT_BITS > evad_pkg::ALPHA_BITS) ? TOT_BITS : evad_pkg::ALPHA_BITS;
  localparam int P_BITS    = MA_BITS + MB_BITS;
  localparam int CMP_BITS  = P_BITS + evad_pkg::THR_FRAC;
  localparam int FP_BITS   = evad_pkg::ALPHA_BITS + DIFF_BITS;  // alpha*|s|
  localparam int RM_BITS   = FP_BITS + 1 - evad_pkg::ALPHA_FRAC;

  localparam int HALF = 1 << (evad_pkg::ALPHA_FRAC - 1);
  localparam logic [RM_BITS-1:0] POS_LIM = RM_BITS'((1 << (FILT_BITS - 1)) - 1);
  localparam logic [RM_BITS-1:0] NEG_LIM = RM_BITS'(1 << (FILT_BITS - 1));

  // ---------------------------------------------------------------------------
  // Configuration registers (write port is always ready)
  // ---------------------------------------------------------------------------
  logic [evad_pkg::ALPHA_BITS-1:0] alpha_q;
  logic                            hpen_q;
  logic [COUNT_BITS-1:0]           total_q, window_q;
  logic [evad_pkg::THR_BITS-1:0]   thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= evad_pkg::ALPHA_BITS'(evad_pkg::ALPHA_RST);
      hpen_q   <= 1'(evad_pkg::ENABLE_RST);
      total_q  <= COUNT_BITS'(evad_pkg::TOTAL_RST);
      window_q <= COUNT_BITS'(evad_pkg::WINDOW_RST);
      thr_q    <= evad_pkg::THR_BITS'(evad_pkg::THR_RST);
    end else if (cfg_i.valid) begin
      case (evad_pkg::cfg_reg_e'(cfg_i.addr))
        evad_pkg::REG_HP_ALPHA:  alpha_q  <= cfg_i.wdata[evad_pkg::ALPHA_BITS-1:0];
        evad_pkg::REG_HP_ENABLE: hpen_q   <= cfg_i.wdata[0];
        evad_pkg::REG_TOTAL:     total_q  <= cfg_i.wdata[COUNT_BITS-1:0];
        evad_pkg::REG_WINDOW:    window_q <= cfg_i.wdata[COUNT_BITS-1:0];
        evad_pkg::REG_THRESHOLD: thr_q    <= cfg_i.wdata[evad_pkg::THR_BITS-1:0];
        default: ;  // unmapped addresses are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Buffer state
  // ---------------------------------------------------------------------------
  evad_pkg::state_e state_q, state_d;

  logic [COUNT_BITS-1:0]         idx_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [FILT_BITS-1:0]   filt_q;
  logic [SUM_BITS-1:0]           sum_all_q, sum_win_q;

  // per-sample working registers
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [FILT_BITS-1:0]   y_q;
  logic                          neg_q;   // sign of y + x - x_prev
  logic [P_BITS-1:0]             lhs_q;   // window sum * buffer length

  // result register
  logic                ovalid_q, oquiet_q, oshort_q;
  logic [SUM_BITS-1:0] oall_q, olast_q;

  // ---------------------------------------------------------------------------
  // Shared digit-serial multiplier: alpha*|s| for each filtered sample, then the three
  // products of the end-of-buffer test.
  // ---------------------------------------------------------------------------
  logic               mul_start, mul_done;
  logic [MA_BITS-1:0] mul_a;
  logic [MB_BITS-1:0] mul_b;
  logic [P_BITS-1:0]  prod;

  evad_dsmul #(
    .A_BITS (MA_BITS),
    .B_BITS (MB_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // ---------------------------------------------------------------------------
  // Datapath terms
  // ---------------------------------------------------------------------------
  logic [TOT_BITS-1:0] total_eff, window_ext, next_idx, win_pos;
  logic                in_acc, use_filt, buf_end, in_win, too_short, out_free, load_out;

  // total 0 stands for 2^COUNT_BITS samples
  assign total_eff  = (total_q == '0) ? {1'b1, {COUNT_BITS{1'b0}}} : {1'b0, total_q};
  assign window_ext = {1'b0, window_q};
  assign too_short  = (window_ext >= total_eff);

  assign in_i.ready = (state_q == evad_pkg::ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;

  // first sample of a buffer passes the filter unchanged
  assign use_filt = hpen_q && (idx_q != '0);

  // s = y_prev + x - x_prev, formed at sample accept
  logic signed [DIFF_BITS-1:0] s_d;
  logic        [DIFF_BITS-1:0] s_mag;

  assign s_d   = DIFF_BITS'(filt_q) + DIFF_BITS'(in_i.sample) - DIFF_BITS'(prev_q);
  assign s_mag = s_d[DIFF_BITS-1] ? DIFF_BITS'(-s_d) : DIFF_BITS'(s_d);

  // round alpha*s / 2^15 half up, then clip to the filter width
  logic [FP_BITS-1:0]          fprod;
  logic [FP_BITS:0]            rnd;
  logic [RM_BITS-1:0]          rmag;
  logic signed [FILT_BITS-1:0] y_filt;

  assign fprod = prod[FP_BITS-1:0];
  // magnitude rounding: +half for positive s, +half-1 for negative (half up on the signed value)
  assign rnd   = {1'b0, fprod} + (neg_q ? (FP_BITS+1)'(HALF - 1) : (FP_BITS+1)'(HALF));
  assign rmag  = RM_BITS'(rnd >> evad_pkg::ALPHA_FRAC);

  always_comb begin
    if (!neg_q) begin
      y_filt = (rmag > POS_LIM) ? FILT_BITS'(POS_LIM) : FILT_BITS'(rmag);
    end else if (rmag > NEG_LIM) begin
      y_filt = {1'b1, {(FILT_BITS-1){1'b0}}};
    end else begin
      y_filt = -FILT_BITS'(rmag);
    end
  end

  // energy accumulation, saturating at the sum width
  logic [FILT_BITS-1:0] mag_y;
  logic [SUM_BITS:0]    all_raw, win_raw;
  logic [SUM_BITS-1:0]  sum_all_nx, sum_win_nx;

  assign mag_y   = y_q[FILT_BITS-1] ? FILT_BITS'(-y_q) : FILT_BITS'(y_q);
  assign win_pos = TOT_BITS'(idx_q) + window_ext;
  assign in_win  = (win_pos >= total_eff);
  assign all_raw = {1'b0, sum_all_q} + (SUM_BITS+1)'(mag_y);
  assign win_raw = {1'b0, sum_win_q} + (SUM_BITS+1)'(mag_y);

  assign sum_all_nx = all_raw[SUM_BITS] ? '1 : all_raw[SUM_BITS-1:0];
  assign sum_win_nx = !in_win ? sum_win_q :
                      (win_raw[SUM_BITS] ? '1 : win_raw[SUM_BITS-1:0]);

  assign next_idx = TOT_BITS'(idx_q) + TOT_BITS'(1);
  assign buf_end  = (next_idx == total_eff);

  // end-of-buffer test: last*total*4096 <= thr*all*window, at full width
  logic quiet;
  assign quiet = !too_short &&
                 ({lhs_q, {evad_pkg::THR_FRAC{1'b0}}} <= CMP_BITS'(prod));

  assign out_free = !ovalid_q || out_o.ready;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= evad_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    load_out  = 1'b0;
    case (state_q)
      evad_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (use_filt) begin
            mul_start = 1'b1;
            mul_a     = MA_BITS'(s_mag);
            mul_b     = MB_BITS'(alpha_q);
            state_d   = evad_pkg::ST_FILT;
          end else begin
            state_d = evad_pkg::ST_ACC;
          end
        end
      end
      evad_pkg::ST_FILT: begin
        if (mul_done) begin
          state_d = evad_pkg::ST_ACC;
        end
      end
      evad_pkg::ST_ACC: begin
        if (buf_end) begin
          // launch last*total straight from the updated window sum
          mul_start = 1'b1;
          mul_a     = MA_BITS'(sum_win_nx);
          mul_b     = MB_BITS'(total_eff);
          state_d   = evad_pkg::ST_LHS;
        end else begin
          state_d = evad_pkg::ST_IDLE;
        end
      end
      evad_pkg::ST_LHS: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MA_BITS'(sum_all_q);
          mul_b     = MB_BITS'(thr_q);
          state_d   = evad_pkg::ST_R1;
        end
      end
      evad_pkg::ST_R1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = prod[MA_BITS-1:0];
          mul_b     = MB_BITS'(window_q);
          state_d   = evad_pkg::ST_RHS;
        end
      end
      evad_pkg::ST_RHS: begin
        // hold the product until the result register is free
        if (mul_done && out_free) begin
          load_out = 1'b1;
          state_d  = evad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = evad_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Filter state, index and sums
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      prev_q    <= '0;
      filt_q    <= '0;
      sum_all_q <= '0;
      sum_win_q <= '0;
    end else if (state_q == evad_pkg::ST_ACC) begin
      sum_all_q <= sum_all_nx;
      sum_win_q <= sum_win_nx;
      if (buf_end) begin
        idx_q  <= '0;
        prev_q <= '0;
        filt_q <= '0;
      end else begin
        idx_q  <= next_idx[COUNT_BITS-1:0];
        prev_q <= x_q;
        filt_q <= y_q;
      end
    end else if (load_out) begin
      sum_all_q <= '0;
      sum_win_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q   <= in_i.sample;
      neg_q <= s_d[DIFF_BITS-1];
      y_q   <= FILT_BITS'(in_i.sample);  // bypass value, replaced when filtering
    end else if (state_q == evad_pkg::ST_FILT && mul_done) begin
      y_q <= y_filt;
    end
    if (state_q == evad_pkg::ST_LHS && mul_done) begin
      lhs_q <= prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: holds one beat while the next buffer streams in
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      oquiet_q <= quiet;
      oshort_q <= too_short;
      oall_q   <= sum_all_q;
      olast_q  <= sum_win_q;
    end
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.quiet_end       = oquiet_q;
  assign out_o.too_short       = oshort_q;
  assign out_o.energy_all_sum  = oall_q;
  assign out_o.energy_last_sum = olast_q;

endmodule

// ===== src/evad_checker.sv =====
// Port-level checks on the result channel of the energy voice activity detector.
module evad_checker #(
  parameter int SUM_BITS = 37
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic                quiet_end_i,
  input logic                too_short_i,
  input logic [SUM_BITS-1:0] all_sum_i,
  input logic [SUM_BITS-1:0] last_sum_i
);

  // a stalled result beat stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_short_not_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(too_short_i && quiet_end_i))
    else $error("quiet_end set with too_short");

  a_window_le_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_sum_i <= all_sum_i))
    else $error("window energy exceeds buffer energy");

  a_silent_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !too_short_i && (last_sum_i == '0) |-> quiet_end_i)
    else $error("silent window not reported quiet");

endmodule

bind energy_voice_activity_detector evad_checker #(
  .SUM_BITS (COUNT_BITS + SAMPLE_BITS + 1)
) u_evad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .quiet_end_i (out_o.quiet_end),
  .too_short_i (out_o.too_short),
  .all_sum_i   (out_o.energy_all_sum),
  .last_sum_i  (out_o.energy_last_sum)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the energy voice activity detector: predictor, scoreboard, drivers.
module testbench;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int COUNT_MASK     = (1 << 20) - 1;
  localparam int FILT_MAX       = (1 << 17) - 1;   // 18-bit signed filter output
  localparam int SETTLE_CYCLES  = 40;              // slowest sample plus end-of-buffer math
  localparam int HOLD_CYCLES    = 300;             // long receiver hold-off
  localparam int RANDOM_ITEMS   = 1600;
  localparam int TIMEOUT_CYCLES = 600000;

  typedef struct {
    logic        quiet_end;
    logic        too_short;
    logic [36:0] all_sum;
    logic [36:0] last_sum;
  } vad_verdict_t;

  // Stimulus waveform shapes for one buffer.
  typedef enum int {
    WAVE_NOISE, WAVE_SOFT, WAVE_RAIL, WAVE_DC, WAVE_FADE_OUT, WAVE_FADE_IN
  } wave_e;

  class vad_scoreboard;
    bit [15:0]    alpha;
    bit           hp_on;
    bit [19:0]    total_reg;
    bit [19:0]    window_reg;
    bit [15:0]    thr;
    int unsigned  idx;
    longint       prev_x;
    longint       filt_y;
    bit [36:0]    sum_all;
    bit [36:0]    sum_win;
    vad_verdict_t verdicts[$];
    int           errors, samples, buffers, quiet_seen, short_seen, writes;

    function new();
      alpha      = 16'(evad_pkg::ALPHA_RST);
      hp_on      = 1'(evad_pkg::ENABLE_RST);
      total_reg  = 20'(evad_pkg::TOTAL_RST);
      window_reg = 20'(evad_pkg::WINDOW_RST);
      thr        = 16'(evad_pkg::THR_RST);
      restart();
    endfunction

    function void restart();
      idx     = 0;
      prev_x  = 0;
      filt_y  = 0;
      sum_all = '0;
      sum_win = '0;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function bit [36:0] add_sat(bit [36:0] acc, longint unsigned mag);
      longint unsigned t;
      t = acc + mag;
      return (t > ((64'd1 << 37) - 1)) ? '1 : t[36:0];
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      writes++;
      case (addr)
        evad_pkg::REG_HP_ALPHA:  alpha      = data[15:0];
        evad_pkg::REG_HP_ENABLE: hp_on      = data[0];
        evad_pkg::REG_TOTAL:     total_reg  = data[19:0];
        evad_pkg::REG_WINDOW:    window_reg = data[19:0];
        evad_pkg::REG_THRESHOLD: thr        = data[15:0];
        default: ;
      endcase
    endfunction

    // One accepted sample beat: filter, accumulate, maybe close the buffer.
    function void note_sample(logic signed [15:0] x);
      longint          xs, s, p, y;
      longint unsigned mag;
      int unsigned     len, win;
      logic [79:0]     lhs, rhs;
      vad_verdict_t    v;
      xs  = longint'(x);
      len = (total_reg == 0) ? COUNT_MASK + 1 : int'(total_reg);
      win = int'(window_reg);
      samples++;
      if (hp_on && idx != 0) begin
        s = filt_y + xs - prev_x;
        p = longint'(alpha) * s;
        // Q1.15 product rounded half toward plus infinity
        if (p >= 0) y = (p + 16384) >>> 15;
        else        y = -((-p + 16383) >>> 15);
        if (y > FILT_MAX)         y = FILT_MAX;
        else if (y < -FILT_MAX-1) y = -FILT_MAX - 1;
      end else begin
        y = xs;
      end
      filt_y = y;
      prev_x = xs;
      mag     = (y < 0) ? -y : y;
      sum_all = add_sat(sum_all, mag);
      if (idx + win >= len) sum_win = add_sat(sum_win, mag);
      if (idx + 1 != len) begin
        idx = (idx + 1) & COUNT_MASK;
        return;
      end
      // Exact ratio test: last*total*4096 <= thr*all*window
      lhs         = 80'(sum_win) * 80'(len) * 80'd4096;
      rhs         = 80'(thr) * 80'(sum_all) * 80'(win);
      v.too_short = (win >= len);
      v.quiet_end = !v.too_short && (lhs <= rhs);
      v.all_sum   = sum_all;
      v.last_sum  = sum_win;
      verdicts    = {verdicts, v};
      buffers++;
      restart();
    endfunction

    function void check_result(logic quiet, logic too_short, logic [36:0] all_sum,
                               logic [36:0] last_sum);
      vad_verdict_t v;
      if (verdicts.size() == 0) begin
        $error("result beat with no buffer outstanding: quiet_end %0d too_short %0d",
               quiet, too_short);
        errors++;
        return;
      end
      v = verdicts.pop_front();
      if (quiet !== v.quiet_end) begin
        $error("quiet_end mismatch: expected %0d, got %0d", v.quiet_end, quiet);
        errors++;
      end
      if (too_short !== v.too_short) begin
        $error("too_short mismatch: expected %0d, got %0d", v.too_short, too_short);
        errors++;
      end
      if (all_sum !== v.all_sum) begin
        $error("energy_all_sum mismatch: expected %0d, got %0d", v.all_sum, all_sum);
        errors++;
      end
      if (last_sum !== v.last_sum) begin
        $error("energy_last_sum mismatch: expected %0d, got %0d", v.last_sum, last_sum);
        errors++;
      end
      if (quiet === 1'b1)     quiet_seen++;
      if (too_short === 1'b1) short_seen++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  evad_sample_if #(.SAMPLE_BITS(16)) smp_ch ();
  evad_result_if #(.SUM_BITS(37))    res_ch ();
  evad_cfg_if                        cfg_ch ();

  energy_voice_activity_detector #(
    .COUNT_BITS  (20),
    .SAMPLE_BITS (16)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_ch.sink),
    .out_o  (res_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  vad_scoreboard      sb;
  bit                 tx_fast;        // sender offers back to back
  bit                 rx_fast;        // receiver never stalls
  bit                 hold_request;   // receiver does one long hold-off
  logic signed [15:0] dc_level;
  int                 sent;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic signed [15:0] wave_sample(wave_e w, int pos, int len);
    case (w)
      WAVE_SOFT:     return 16'($urandom_range(0, 64) - 32);
      WAVE_RAIL:     return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      WAVE_DC:       return dc_level;
      WAVE_FADE_OUT: return (2 * pos < len) ? 16'($urandom) : 16'($urandom_range(0, 16) - 8);
      WAVE_FADE_IN:  return (2 * pos < len) ? 16'($urandom_range(0, 16) - 8) : 16'($urandom);
      default:       return 16'($urandom);
    endcase
  endfunction

  // Random upper bits on a register write; the block keeps only the field width.
  function automatic logic [31:0] with_junk(logic [31:0] v, int w);
    return ($urandom_range(0, 1) ? ($urandom << w) : 32'd0) | v;
  endfunction

  // Valid is left high after a beat; a gap or a settle lowers it.
  task automatic send_sample(input logic signed [15:0] x);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_ch.valid  <= 1'b1;
    smp_ch.sample <= x;
    do @(posedge clk_i); while (!smp_ch.ready);
    sb.note_sample(x);
    sent++;
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.wdata <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(addr, data);
  endtask

  // Block idle: nothing outstanding, plus time for a sample still in the pipe.
  task automatic settle();
    smp_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_buffer(input int len);
    wave_e w;
    w        = wave_e'($urandom_range(0, 5));
    dc_level = 16'($urandom);
    for (int pos = 0; pos < len; pos++) send_sample(wave_sample(w, pos, len));
  endtask

  // Result side: per-beat random stall, occasional stall-free stretches, one long hold.
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = rx_fast ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      sb.check_result(res_ch.quiet_end, res_ch.too_short,
                      res_ch.energy_all_sum, res_ch.energy_last_sum);
      if ($urandom_range(0, 19) == 0) rx_fast = ~rx_fast;
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int          len;
    logic [19:0] total, window;
    logic [15:0] alpha, thr;
    logic [2:0]  unmapped;
    sb            = new();
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    smp_ch.valid  = 1'b0;
    smp_ch.sample = '0;
    res_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.addr   = '0;
    cfg_ch.wdata  = '0;
    tx_fast       = 1'b0;
    rx_fast       = 1'b0;
    hold_request  = 1'b0;
    dc_level      = '0;
    sent          = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // ---- Directed part ----
    // Reset defaults: rails and zero into a long buffer, then shorten it mid-buffer;
    // the default window is longer than the shortened buffer so the result is too short.
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    settle();
    write_reg(evad_pkg::REG_TOTAL, 32'd5);
    cfg_ch.valid <= 1'b0;
    send_sample(16'sh0001);
    send_sample(16'shFFFF);

    // Gain near two on alternating rails: filter output saturates.
    settle();
    write_reg(evad_pkg::REG_HP_ALPHA, 32'd65535);
    write_reg(evad_pkg::REG_HP_ENABLE, 32'd1);
    write_reg(evad_pkg::REG_WINDOW, 32'd2);
    write_reg(evad_pkg::REG_THRESHOLD, 32'd65535);
    cfg_ch.valid <= 1'b0;
    for (int k = 0; k < 5; k++) send_sample(k[0] ? 16'sh8000 : 16'sh7FFF);

    // Filter bypassed, empty window: quiet end with a zero last sum.
    settle();
    write_reg(evad_pkg::REG_HP_ENABLE, 32'd0);
    write_reg(evad_pkg::REG_WINDOW, 32'd0);
    write_reg(evad_pkg::REG_TOTAL, 32'd3);
    cfg_ch.valid <= 1'b0;
    send_sample(16'sh0000);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);

    // One-sample buffers: window equal to the buffer, then empty window; zero alpha.
    settle();
    write_reg(evad_pkg::REG_HP_ENABLE, 32'd1);
    write_reg(evad_pkg::REG_HP_ALPHA, 32'd0);
    write_reg(evad_pkg::REG_TOTAL, 32'd1);
    write_reg(evad_pkg::REG_WINDOW, 32'd1);
    cfg_ch.valid <= 1'b0;
    send_sample(16'sh8000);
    settle();
    write_reg(evad_pkg::REG_WINDOW, 32'd0);
    cfg_ch.valid <= 1'b0;
    send_sample(16'sh0005);

    // Zero threshold, an address past the register map (ignored), full-length buffer
    // codes, the second one written mid-buffer, then the buffer cut back while the index is below it.
    settle();
    unmapped = evad_pkg::REG_THRESHOLD + 3'd1;
    write_reg(evad_pkg::REG_THRESHOLD, 32'd0);
    write_reg(unmapped, 32'hFFFF_FFFF);
    write_reg(evad_pkg::REG_HP_ALPHA, 32'd32768);
    write_reg(evad_pkg::REG_TOTAL, 32'd0);
    write_reg(evad_pkg::REG_WINDOW, 32'd1);
    cfg_ch.valid <= 1'b0;
    send_sample(16'sh1234);
    send_sample(16'shEDCB);
    settle();
    write_reg(evad_pkg::REG_TOTAL, 32'd1048575);
    cfg_ch.valid <= 1'b0;
    send_sample(16'sh4000);
    settle();
    write_reg(evad_pkg::REG_WINDOW, 32'd1048575);
    write_reg(evad_pkg::REG_TOTAL, 32'd6);
    cfg_ch.valid <= 1'b0;
    send_sample(16'shC000);
    send_sample(16'sh0100);
    send_sample(16'shFF00);

    // ---- Back-pressure: one result per sample while the receiver holds off ----
    settle();
    write_reg(evad_pkg::REG_TOTAL, 32'd1);
    write_reg(evad_pkg::REG_WINDOW, 32'd0);
    cfg_ch.valid <= 1'b0;
    hold_request = 1'b1;
    tx_fast      = 1'b1;
    for (int k = 0; k < 24; k++) send_sample(16'($urandom));
    tx_fast = 1'b0;

    // ---- Random part: whole buffers under a fresh setting each phase ----
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      tx_fast = ($urandom_range(0, 3) == 0);
      total   = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(25, 120)) :
                                              20'($urandom_range(1, 24));
      case ($urandom_range(0, 9))
        0:       window = '0;
        1:       window = total;
        2:       window = 20'(total + $urandom_range(1, 6));
        3:       window = 20'(COUNT_MASK);
        default: window = (total > 1) ? 20'($urandom_range(1, total - 1)) : '0;
      endcase
      case ($urandom_range(0, 7))
        0:       alpha = '0;
        1:       alpha = 16'd32768;
        2:       alpha = 16'd65535;
        3:       alpha = 16'($urandom_range(0, 65535));
        default: alpha = 16'($urandom_range(24000, 32768));
      endcase
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = 16'd65535;
        2:       thr = 16'($urandom_range(0, 65535));
        default: thr = 16'($urandom_range(2048, 6144));
      endcase
      write_reg(evad_pkg::REG_TOTAL, with_junk(32'(total), 20));
      if ($urandom_range(0, 3) != 0) write_reg(evad_pkg::REG_WINDOW, with_junk(32'(window), 20));
      if ($urandom_range(0, 3) != 0) write_reg(evad_pkg::REG_HP_ALPHA, with_junk(32'(alpha), 16));
      if ($urandom_range(0, 3) != 0)
        write_reg(evad_pkg::REG_HP_ENABLE, with_junk(32'($urandom_range(0, 3) != 0), 1));
      if ($urandom_range(0, 3) != 0) write_reg(evad_pkg::REG_THRESHOLD, with_junk(32'(thr), 16));
      cfg_ch.valid <= 1'b0;
      len = (total == 0) ? COUNT_MASK + 1 : int'(total);
      repeat ($urandom_range(1, 3)) send_buffer(len);
    end

    // ---- Drain ----
    settle();
    sb.errors += sb.pending();
    $display("Run covered %0d samples in %0d buffers with %0d register writes.",
             sb.samples, sb.buffers, sb.writes);
    $display("Results: %0d quiet ends, %0d too-short windows.", sb.quiet_seen, sb.short_seen);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/evad_pkg.sv
src/evad_if.sv
src/evad_dsmul.sv
src/energy_voice_activity_detector.sv
src/evad_checker.sv
tb/testbench.sv
